FILE: design/idpt_pkg.sv
// Shared types and constants of the instruction decoder with page table.
package idpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int PAGE_W   = 20;
  localparam int FRAME_W  = 8;
  localparam int OFFS_W   = 12;
  localparam int INDEX_W  = 4;
  localparam int KIND_W   = 4;
  localparam int REGA_W   = 4;
  localparam int REGB_W   = 5;
  localparam int ADDR_W   = 20;
  localparam int LIT_W    = 32;
  localparam int ERR_W    = 2;
  localparam int LEFT_W   = 3;

  localparam logic [7:0] OP_MOV_RR   = 8'h1A;
  localparam logic [7:0] OP_MOV_ADDR = 8'h1B;
  localparam logic [7:0] OP_MUL_RR   = 8'h20;
  localparam logic [7:0] OP_MUL_ADDR = 8'h22;
  localparam logic [7:0] OP_JG_SHIFT = 8'h94;
  localparam logic [7:0] OP_JG_ADDR  = 8'h95;
  localparam logic [7:0] OP_CMP_RR   = 8'h80;
  localparam logic [7:0] OP_MOV_LIT  = 8'h1C;

  localparam logic [KIND_W-1:0] KIND_MOV_RR    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_MOV_ADDR  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL_RR    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MUL_ADDR  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_JG_SHIFT  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_JG_ADDR   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_CMP_RR    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MOV_LIT8  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_MOV_LIT32 = 4'd8;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OPCODE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_VARIATION = 2'd2;
  localparam logic [ERR_W-1:0] ERR_PAGE      = 2'd3;

  localparam logic [3:0] NIB_LIT8  = 4'h0;
  localparam logic [3:0] NIB_LIT32 = 4'h2;

  localparam logic [LEFT_W-1:0] LEFT_ONE  = 3'd1;
  localparam logic [LEFT_W-1:0] LEFT_FOUR = 3'd4;
  localparam logic [LEFT_W-1:0] LEFT_FIVE = 3'd5;

  typedef struct packed {
    logic               vld;
    logic [PAGE_W-1:0]  page;
    logic               found;
    logic [FRAME_W-1:0] frame;
  } srch_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [PAGE_W-1:0]  page;
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } wr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REGA_W-1:0] reg_a;
    logic [REGB_W-1:0] reg_b;
    logic [ADDR_W-1:0] address;
    logic [LIT_W-1:0]  literal;
    logic [ERR_W-1:0]  error_code;
  } res_t;

endpackage

FILE: design/idpt_cell.sv
// One page table entry and one stage of the lookup chain.
module idpt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  idpt_pkg::wr_t   wr,
  input  idpt_pkg::srch_t up,
  output idpt_pkg::srch_t dn
);

  logic                         valid_r;
  logic [idpt_pkg::PAGE_W-1:0]  page_r;
  logic [idpt_pkg::FRAME_W-1:0] frame_r;
  logic                         vld_r;
  logic [idpt_pkg::PAGE_W-1:0]  s_page_r;
  logic                         s_found_r;
  logic [idpt_pkg::FRAME_W-1:0] s_frame_r;
  logic                         sel;
  logic                         hit;

  assign sel = wr.en && (32'(wr.index) == 32'(CELL_INDEX));
  assign hit = valid_r && (page_r == up.page);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      vld_r <= up.vld;
      if (sel) begin
        valid_r <= wr.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      page_r  <= wr.page;
      frame_r <= wr.valid ? wr.frame : '0;
    end
    s_page_r  <= up.page;
    s_found_r <= up.found || hit;
    s_frame_r <= up.found ? up.frame : frame_r;
  end

  assign dn.vld   = vld_r;
  assign dn.page  = s_page_r;
  assign dn.found = s_found_r;
  assign dn.frame = s_frame_r;

endmodule

FILE: design/idpt_decoder.sv
// Byte collector, result builder and two-entry result queue.
module idpt_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_acc,
  input  logic [7:0]                    byte_in,
  input  idpt_pkg::srch_t               rsp,
  output idpt_pkg::srch_t               req,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output idpt_pkg::res_t                out_res
);

  typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_LITREG, PH_SEARCH} phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [idpt_pkg::KIND_W-1:0]       kind_r, kind_nxt;
  logic [idpt_pkg::LEFT_W-1:0]       left_r, left_nxt;
  logic [idpt_pkg::LIT_W-1:0]        oper_r, oper_nxt;
  logic [7:0]                        regb_r, regb_nxt;
  idpt_pkg::srch_t                   req_r, req_nxt;
  idpt_pkg::res_t                    head_r, skid_r, res;
  logic                              head_vld_r, skid_vld_r;
  logic                              push, pop;
  logic [idpt_pkg::LIT_W-1:0]        shifted;

  assign shifted = {oper_r[23:0], byte_in};
  assign pop     = head_vld_r && !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    left_nxt  = left_r;
    oper_nxt  = oper_r;
    regb_nxt  = regb_r;
    req_nxt   = req_r;
    req_nxt.vld   = 1'b0;
    req_nxt.found = 1'b0;
    req_nxt.frame = '0;
    push = 1'b0;
    res  = '0;
    if (phase_r == PH_SEARCH) begin
      if (rsp.vld) begin
        push      = 1'b1;
        phase_nxt = PH_IDLE;
        left_nxt  = '0;
        res.kind  = kind_r;
        if (rsp.found) begin
          res.reg_a   = (kind_r == idpt_pkg::KIND_JG_ADDR) ? '0 : regb_r[3:0];
          res.address = {rsp.frame, oper_r[idpt_pkg::OFFS_W-1:0]};
        end else begin
          res.error_code = idpt_pkg::ERR_PAGE;
        end
      end
    end else if (byte_acc) begin
      case (phase_r)
        PH_IDLE: begin
          oper_nxt  = '0;
          regb_nxt  = '0;
          phase_nxt = PH_COLLECT;
          case (byte_in)
            idpt_pkg::OP_MOV_RR: begin
              kind_nxt = idpt_pkg::KIND_MOV_RR;
              left_nxt = idpt_pkg::LEFT_ONE;
            end
            idpt_pkg::OP_MOV_ADDR: begin
              kind_nxt = idpt_pkg::KIND_MOV_ADDR;
              left_nxt = idpt_pkg::LEFT_FIVE;
            end
            idpt_pkg::OP_MUL_RR: begin
              kind_nxt = idpt_pkg::KIND_MUL_RR;
              left_nxt = idpt_pkg::LEFT_ONE;
            end
            idpt_pkg::OP_MUL_ADDR: begin
              kind_nxt = idpt_pkg::KIND_MUL_ADDR;
              left_nxt = idpt_pkg::LEFT_FIVE;
            end
            idpt_pkg::OP_JG_SHIFT: begin
              kind_nxt = idpt_pkg::KIND_JG_SHIFT;
              left_nxt = idpt_pkg::LEFT_ONE;
            end
            idpt_pkg::OP_JG_ADDR: begin
              kind_nxt = idpt_pkg::KIND_JG_ADDR;
              left_nxt = idpt_pkg::LEFT_FOUR;
            end
            idpt_pkg::OP_CMP_RR: begin
              kind_nxt = idpt_pkg::KIND_CMP_RR;
              left_nxt = idpt_pkg::LEFT_ONE;
            end
            idpt_pkg::OP_MOV_LIT: begin
              phase_nxt = PH_LITREG;
              left_nxt  = idpt_pkg::LEFT_ONE;
            end
            default: begin
              phase_nxt      = PH_IDLE;
              push           = 1'b1;
              res.error_code = idpt_pkg::ERR_OPCODE;
            end
          endcase
        end
        PH_LITREG: begin
          regb_nxt = byte_in;
          oper_nxt = '0;
          if (byte_in[7:4] == idpt_pkg::NIB_LIT8) begin
            phase_nxt = PH_COLLECT;
            kind_nxt  = idpt_pkg::KIND_MOV_LIT8;
            left_nxt  = idpt_pkg::LEFT_ONE;
          end else if (byte_in[7:4] == idpt_pkg::NIB_LIT32) begin
            phase_nxt = PH_COLLECT;
            kind_nxt  = idpt_pkg::KIND_MOV_LIT32;
            left_nxt  = idpt_pkg::LEFT_FOUR;
          end else begin
            phase_nxt      = PH_IDLE;
            left_nxt       = '0;
            push           = 1'b1;
            res.kind       = idpt_pkg::KIND_MOV_LIT8;
            res.error_code = idpt_pkg::ERR_VARIATION;
          end
        end
        PH_COLLECT: begin
          if ((kind_r == idpt_pkg::KIND_MOV_ADDR || kind_r == idpt_pkg::KIND_MUL_ADDR)
              && left_r == idpt_pkg::LEFT_FIVE) begin
            regb_nxt = byte_in;
            left_nxt = idpt_pkg::LEFT_FOUR;
          end else begin
            oper_nxt = shifted;
            if (left_r > idpt_pkg::LEFT_ONE) begin
              left_nxt = left_r - idpt_pkg::LEFT_ONE;
            end else begin
              phase_nxt = PH_IDLE;
              left_nxt  = '0;
              res.kind  = kind_r;
              case (kind_r)
                idpt_pkg::KIND_MOV_RR, idpt_pkg::KIND_MUL_RR, idpt_pkg::KIND_CMP_RR: begin
                  push      = 1'b1;
                  res.reg_a = byte_in[7:4];
                  res.reg_b = byte_in[4:0];
                end
                idpt_pkg::KIND_JG_SHIFT: begin
                  push        = 1'b1;
                  res.literal = {24'd0, byte_in};
                end
                idpt_pkg::KIND_MOV_LIT8: begin
                  push        = 1'b1;
                  res.reg_a   = regb_r[3:0];
                  res.literal = {24'd0, byte_in};
                end
                idpt_pkg::KIND_MOV_LIT32: begin
                  push        = 1'b1;
                  res.reg_a   = regb_r[3:0];
                  res.literal = shifted;
                end
                idpt_pkg::KIND_MOV_ADDR, idpt_pkg::KIND_MUL_ADDR: begin
                  if (regb_r[7:4] != 4'd0) begin
                    push           = 1'b1;
                    res.error_code = idpt_pkg::ERR_VARIATION;
                  end else begin
                    phase_nxt    = PH_SEARCH;
                    req_nxt.vld  = 1'b1;
                    req_nxt.page = shifted[idpt_pkg::LIT_W-1:idpt_pkg::OFFS_W];
                  end
                end
                idpt_pkg::KIND_JG_ADDR: begin
                  phase_nxt    = PH_SEARCH;
                  req_nxt.vld  = 1'b1;
                  req_nxt.page = shifted[idpt_pkg::LIT_W-1:idpt_pkg::OFFS_W];
                end
                default: begin
                  push           = 1'b1;
                  res.kind       = idpt_pkg::KIND_MOV_RR;
                  res.error_code = idpt_pkg::ERR_OPCODE;
                end
              endcase
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      left_r     <= '0;
      oper_r     <= '0;
      regb_r     <= '0;
      kind_r     <= '0;
      req_r      <= '0;
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      oper_r  <= oper_nxt;
      regb_r  <= regb_nxt;
      kind_r  <= kind_nxt;
      req_r   <= req_nxt;
      if (pop) begin
        if (skid_vld_r) begin
          head_vld_r <= 1'b1;
          skid_vld_r <= push;
        end else begin
          head_vld_r <= push;
        end
      end else if (push) begin
        if (!head_vld_r) begin
          head_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        head_r <= skid_r;
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end else if (push) begin
      if (!head_vld_r) begin
        head_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign req       = req_r;
  assign busy      = (phase_r == PH_SEARCH) || skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_res   = head_r;

endmodule

FILE: design/instruction_decoder_with_page_table_core.sv
// Top level: instruction byte decoder with a chained page table lookup.
// The completing byte writes its result into the registered result queue; address forms
// first send their page through a lookup request register and the chain of entry cells.
// Throughput: one load or byte per cycle; stalls during a lookup or with the queue full.
// A two-entry result queue lets input continue while one result waits.
// Reset (synchronous, rst_n low): all table entries invalid, decoder waits for an opcode.
module instruction_decoder_with_page_table_core #(
  parameter int TABLE_ENTRIES = idpt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [idpt_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [idpt_pkg::PAGE_W-1:0]    in_page_number,
  input  logic                           in_entry_valid,
  input  logic [idpt_pkg::FRAME_W-1:0]   in_frame,
  input  logic [7:0]                     in_byte_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [idpt_pkg::KIND_W-1:0]    out_kind,
  output logic [idpt_pkg::REGA_W-1:0]    out_reg_a,
  output logic [idpt_pkg::REGB_W-1:0]    out_reg_b,
  output logic [idpt_pkg::ADDR_W-1:0]    out_address,
  output logic [idpt_pkg::LIT_W-1:0]     out_literal,
  output logic [idpt_pkg::ERR_W-1:0]     out_error_code
);

  logic            acc;
  logic            busy;
  idpt_pkg::wr_t   wr;
  idpt_pkg::srch_t chain [TABLE_ENTRIES+1];
  idpt_pkg::res_t  res;

  assign acc      = in_valid && !in_stall;
  assign in_stall = busy;

  assign wr.en    = acc && !in_action;
  assign wr.index = in_entry_index;
  assign wr.page  = in_page_number;
  assign wr.valid = in_entry_valid;
  assign wr.frame = in_frame;

  idpt_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (acc && in_action),
    .byte_in   (in_byte_in),
    .rsp       (chain[TABLE_ENTRIES]),
    .req       (chain[0]),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    idpt_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (wr),
      .up    (chain[i]),
      .dn    (chain[i+1])
    );
  end

  assign out_kind       = res.kind;
  assign out_reg_a      = res.reg_a;
  assign out_reg_b      = res.reg_b;
  assign out_address    = res.address;
  assign out_literal    = res.literal;
  assign out_error_code = res.error_code;

endmodule

FILE: design/idpt_checker.sv
// Port-level checks of the instruction decoder core and their binding.
module idpt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [idpt_pkg::KIND_W-1:0]    out_kind,
  input logic [idpt_pkg::REGA_W-1:0]    out_reg_a,
  input logic [idpt_pkg::REGB_W-1:0]    out_reg_b,
  input logic [idpt_pkg::ADDR_W-1:0]    out_address,
  input logic [idpt_pkg::LIT_W-1:0]     out_literal,
  input logic [idpt_pkg::ERR_W-1:0]     out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_literal)
      && $stable(out_address) && $stable(out_error_code))
    else $error("result changed while stalled");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != idpt_pkg::ERR_OK |->
      out_reg_a == '0 && out_reg_b == '0 && out_address == '0 && out_literal == '0)
    else $error("error result carries payload");

  a_addr_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_address != '0 |->
      out_kind == idpt_pkg::KIND_MOV_ADDR || out_kind == idpt_pkg::KIND_MUL_ADDR
      || out_kind == idpt_pkg::KIND_JG_ADDR)
    else $error("address on a form without address");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= idpt_pkg::KIND_MOV_LIT32)
    else $error("kind out of range");

endmodule

bind instruction_decoder_with_page_table_core idpt_checker u_idpt_checker (.*);

FILE: bench/idpt_decode_checker.sv
// Checker for the instruction decoder: predicts each decoded result and compares in order.
module idpt_decode_checker
  import idpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic               in_entry_valid,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic [7:0]         in_byte_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [KIND_W-1:0]  out_kind,
  input  logic [REGA_W-1:0]  out_reg_a,
  input  logic [REGB_W-1:0]  out_reg_b,
  input  logic [ADDR_W-1:0]  out_address,
  input  logic [LIT_W-1:0]   out_literal,
  input  logic [ERR_W-1:0]   out_error_code,
  output int                 mismatch_count,
  output int                 outstanding,
  output int                 decoded_count,
  output int                 error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {DEC_OPCODE, DEC_LIT_REG, DEC_OPERANDS} dec_state_e;

  dec_state_e         dstate;
  logic [KIND_W-1:0]  cur_kind;
  logic [LEFT_W-1:0]  left_cnt;
  logic [31:0]        operand_acc;
  logic [7:0]         reg_byte;
  logic [PAGE_W-1:0]  tbl_page  [TABLE_ENTRIES];
  logic               tbl_vld   [TABLE_ENTRIES];
  logic [FRAME_W-1:0] tbl_frame [TABLE_ENTRIES];
  res_t               expected_q[$];

  function automatic void start_operands(input logic [KIND_W-1:0] k,
                                         input logic [LEFT_W-1:0] n);
    dstate   = DEC_OPERANDS;
    cur_kind = k;
    left_cnt = n;
  endfunction

  function automatic bit lookup(input logic [31:0] va, output logic [ADDR_W-1:0] pa);
    bit hit;
    hit = 1'b0;
    pa  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && tbl_vld[i] && tbl_page[i] == va[31:OFFS_W]) begin
        hit = 1'b1;
        pa  = {tbl_frame[i], va[OFFS_W-1:0]};
      end
    end
    return hit;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output res_t r);
    logic [ADDR_W-1:0] pa;
    r = '0;
    case (dstate)
      DEC_OPCODE: begin
        operand_acc = '0;
        reg_byte    = '0;
        case (b)
          OP_MOV_RR:   start_operands(KIND_MOV_RR, LEFT_ONE);
          OP_MOV_ADDR: start_operands(KIND_MOV_ADDR, LEFT_FIVE);
          OP_MUL_RR:   start_operands(KIND_MUL_RR, LEFT_ONE);
          OP_MUL_ADDR: start_operands(KIND_MUL_ADDR, LEFT_FIVE);
          OP_JG_SHIFT: start_operands(KIND_JG_SHIFT, LEFT_ONE);
          OP_JG_ADDR:  start_operands(KIND_JG_ADDR, LEFT_FOUR);
          OP_CMP_RR:   start_operands(KIND_CMP_RR, LEFT_ONE);
          OP_MOV_LIT:  dstate = DEC_LIT_REG;
          default: begin
            r.error_code = ERR_OPCODE;
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      DEC_LIT_REG: begin
        reg_byte    = b;
        operand_acc = '0;
        if (b[7:4] == NIB_LIT8) begin
          start_operands(KIND_MOV_LIT8, LEFT_ONE);
        end else if (b[7:4] == NIB_LIT32) begin
          start_operands(KIND_MOV_LIT32, LEFT_FOUR);
        end else begin
          dstate       = DEC_OPCODE;
          r.kind       = KIND_MOV_LIT8;
          r.error_code = ERR_VARIATION;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if ((cur_kind == KIND_MOV_ADDR || cur_kind == KIND_MUL_ADDR) && left_cnt == LEFT_FIVE)
        begin
          reg_byte = b;
          left_cnt = LEFT_FOUR;
          return 1'b0;
        end
        operand_acc = {operand_acc[23:0], b};
        if (left_cnt > LEFT_ONE) begin
          left_cnt--;
          return 1'b0;
        end
        dstate = DEC_OPCODE;
        r.kind = cur_kind;
        case (cur_kind)
          KIND_MOV_RR, KIND_MUL_RR, KIND_CMP_RR: begin
            r.reg_a = b[7:4];
            r.reg_b = b[4:0];
          end
          KIND_JG_SHIFT: r.literal = {24'd0, b};
          KIND_MOV_LIT8: begin
            r.reg_a   = reg_byte[3:0];
            r.literal = {24'd0, b};
          end
          KIND_MOV_LIT32: begin
            r.reg_a   = reg_byte[3:0];
            r.literal = operand_acc;
          end
          KIND_MOV_ADDR, KIND_MUL_ADDR: begin
            if (reg_byte[7:4] != 4'h0) begin
              r.error_code = ERR_VARIATION;
            end else if (!lookup(operand_acc, pa)) begin
              r.error_code = ERR_PAGE;
            end else begin
              r.reg_a   = reg_byte[3:0];
              r.address = pa;
            end
          end
          KIND_JG_ADDR: begin
            if (!lookup(operand_acc, pa)) r.error_code = ERR_PAGE;
            else r.address = pa;
          end
          default: begin
            r.kind       = KIND_MOV_RR;
            r.error_code = ERR_OPCODE;
          end
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      decoded_count  = 0;
      error_count    = 0;
      dstate         = DEC_OPCODE;
      cur_kind       = KIND_MOV_RR;
      left_cnt       = '0;
      operand_acc    = '0;
      reg_byte       = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_vld[i]   = 1'b0;
        tbl_page[i]  = '0;
        tbl_frame[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        decoded_count++;
        if (out_error_code != ERR_OK) error_count++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d error_code %0d", out_kind,
                 out_error_code);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("reg_a", want.reg_a, out_reg_a);
          check_field("reg_b", want.reg_b, out_reg_b);
          check_field("address", want.address, out_address);
          check_field("literal", want.literal, out_literal);
          check_field("error_code", want.error_code, out_error_code);
        end
      end
      if (in_valid && !in_stall) begin
        if (!in_action) begin
          if (in_entry_index < TABLE_ENTRIES) begin
            tbl_page[in_entry_index]  = in_page_number;
            tbl_vld[in_entry_index]   = in_entry_valid;
            tbl_frame[in_entry_index] = in_entry_valid ? in_frame : '0;
          end
        end else if (decode_byte(in_byte_in, want)) begin
          expected_q = {expected_q, want};
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: bench/instruction_decoder_with_page_table_core_tb.sv
// Testbench top: drives table loads and instruction bytes into the decoder and gives the verdict.
module instruction_decoder_with_page_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idpt_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [INDEX_W-1:0] in_entry_index;
  logic [PAGE_W-1:0]  in_page_number;
  logic               in_entry_valid;
  logic [FRAME_W-1:0] in_frame;
  logic [7:0]         in_byte_in;
  logic               out_valid;
  logic               out_stall;
  logic [KIND_W-1:0]  out_kind;
  logic [REGA_W-1:0]  out_reg_a;
  logic [REGB_W-1:0]  out_reg_b;
  logic [ADDR_W-1:0]  out_address;
  logic [LIT_W-1:0]   out_literal;
  logic [ERR_W-1:0]   out_error_code;

  int mismatch_count;
  int outstanding;
  int decoded_count;
  int error_count;

  int                items_sent;
  int                loads_sent;
  int                burst_left;
  int                no_gap;
  int                hold_ask;
  logic [PAGE_W-1:0] live_page [TABLE_ENTRIES_DEF];
  logic              live_vld  [TABLE_ENTRIES_DEF];

  always #4 clk = ~clk;

  instruction_decoder_with_page_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES_DEF)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_page_number (in_page_number),
    .in_entry_valid (in_entry_valid),
    .in_frame       (in_frame),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_reg_a      (out_reg_a),
    .out_reg_b      (out_reg_b),
    .out_address    (out_address),
    .out_literal    (out_literal),
    .out_error_code (out_error_code)
  );

  idpt_decode_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES_DEF)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_page_number (in_page_number),
    .in_entry_valid (in_entry_valid),
    .in_frame       (in_frame),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_reg_a      (out_reg_a),
    .out_reg_b      (out_reg_b),
    .out_address    (out_address),
    .out_literal    (out_literal),
    .out_error_code (out_error_code),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .decoded_count  (decoded_count),
    .error_count    (error_count)
  );

  task automatic offer(input logic act, input logic [INDEX_W-1:0] idx,
                       input logic [PAGE_W-1:0] pg, input logic v,
                       input logic [FRAME_W-1:0] fr, input logic [7:0] b);
    int gap;
    if (no_gap > 0) begin
      no_gap--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx;
    in_page_number <= pg;
    in_entry_valid <= v;
    in_frame       <= fr;
    in_byte_in     <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!act) loads_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    offer(1'b1, 4'($urandom_range(0, 15)), 20'($urandom_range(0, 20'hFFFFF)),
          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), b);
  endtask

  task automatic put_load(input logic [INDEX_W-1:0] idx, input logic [PAGE_W-1:0] pg,
                          input logic v, input logic [FRAME_W-1:0] fr);
    live_page[idx] = pg;
    live_vld[idx]  = v;
    offer(1'b0, idx, pg, v, fr, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_load();
    logic [PAGE_W-1:0] pg;
    case ($urandom_range(0, 7))
      0, 1:    pg = live_page[4'($urandom_range(0, TABLE_ENTRIES_DEF - 1))];
      2:       pg = '0;
      3:       pg = '1;
      default: pg = 20'($urandom_range(0, 20'hFFFFF));
    endcase
    put_load(4'($urandom_range(0, 15)), pg, $urandom_range(0, 3) != 0,
             8'($urandom_range(0, 255)));
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 24) == 0) random_load();
      put_byte(w[8*i +: 8]);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_vaddr();
    logic [31:0] va;
    int          s;
    va = $urandom;
    if ($urandom_range(0, 4) != 0) begin
      s = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
      for (int k = 0; k < TABLE_ENTRIES_DEF && !live_vld[s]; k++)
        s = (s + 1) % TABLE_ENTRIES_DEF;
      va[31:OFFS_W] = live_page[s];
    end
    case ($urandom_range(0, 5))
      0:       va[OFFS_W-1:0] = '0;
      1:       va[OFFS_W-1:0] = '1;
      default: ;
    endcase
    return va;
  endfunction

  function automatic logic [7:0] addr_reg_byte();
    logic [7:0] rb;
    rb = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) rb[7:4] = 4'h0;
    return rb;
  endfunction

  task automatic random_instr();
    logic [7:0] rb;
    case ($urandom_range(0, 7))
      0: begin
        put_byte(OP_MOV_RR);
        put_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        put_byte(OP_MOV_ADDR);
        put_byte(addr_reg_byte());
        put_word(pick_vaddr());
      end
      2: begin
        put_byte(OP_MUL_RR);
        put_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        put_byte(OP_MUL_ADDR);
        put_byte(addr_reg_byte());
        put_word(pick_vaddr());
      end
      4: begin
        put_byte(OP_JG_SHIFT);
        put_byte(8'($urandom_range(0, 255)));
      end
      5: begin
        put_byte(OP_JG_ADDR);
        put_word(pick_vaddr());
      end
      6: begin
        put_byte(OP_CMP_RR);
        put_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        rb = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0:       ;
          1, 2, 3, 4: rb[7:4] = NIB_LIT8;
          default: rb[7:4] = NIB_LIT32;
        endcase
        put_byte(OP_MOV_LIT);
        put_byte(rb);
        if (rb[7:4] == NIB_LIT8) put_byte(8'($urandom_range(0, 255)));
        else if (rb[7:4] == NIB_LIT32) put_word($urandom);
      end
    endcase
  endtask

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    out_stall  = 1'b0;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_ask) begin
        holds_done++;
        hold_left = 90;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int next_hold;
    bit paused;
    int waited;
    int pick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = 1'b0;
    in_entry_index = '0;
    in_page_number = '0;
    in_entry_valid = 1'b0;
    in_frame       = '0;
    in_byte_in     = '0;
    items_sent     = 0;
    loads_sent     = 0;
    burst_left     = 0;
    no_gap         = 0;
    hold_ask       = 0;
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      live_page[i] = '0;
      live_vld[i]  = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // table extremes, duplicate page, invalid entry
    put_load(4'd0, 20'h00000, 1'b1, 8'h00);
    put_load(4'd15, 20'hFFFFF, 1'b1, 8'hFF);
    put_load(4'd2, 20'hABCDE, 1'b1, 8'h11);
    put_load(4'd5, 20'hABCDE, 1'b1, 8'h22);
    put_load(4'd7, 20'h12345, 1'b0, 8'h5A);

    put_byte(OP_MOV_RR);   put_byte(8'hFF);
    put_byte(OP_MUL_RR);   put_byte(8'h00);
    put_byte(OP_CMP_RR);   put_byte(8'hA5);
    put_byte(OP_JG_SHIFT); put_byte(8'hFF);
    put_byte(OP_MOV_ADDR); put_byte(8'h0F); put_word(32'hFFFFFFFF);
    put_byte(OP_MUL_ADDR); put_byte(8'h00); put_word(32'h00000000);
    put_byte(OP_JG_ADDR);  put_word(32'hABCDE123);
    put_byte(OP_MOV_ADDR); put_byte(8'h01); put_word(32'h12345678);
    put_byte(OP_MUL_ADDR); put_byte(8'h30); put_word(32'hFFFFF000);
    put_byte(OP_MOV_LIT);  put_byte(8'h0F); put_byte(8'h80);
    put_byte(OP_MOV_LIT);  put_byte(8'h2A); put_word(32'hDEADBEEF);
    put_byte(OP_MOV_LIT);  put_byte(8'h10);
    put_byte(8'h00);
    put_byte(8'hFF);
    // table write between the address bytes of one instruction
    put_byte(OP_MOV_ADDR); put_byte(8'h03); put_byte(8'h00); put_byte(8'h04);
    put_load(4'd1, 20'h00042, 1'b1, 8'h7E);
    put_byte(8'h2A); put_byte(8'hBC);
    wait_drained();

    next_hold = 150;
    paused    = 1'b0;
    while (items_sent < 460) begin
      if (items_sent >= next_hold) begin
        hold_ask++;
        no_gap    = 30;
        next_hold += 170;
      end
      if (!paused && items_sent >= 260) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) random_load();
      else if (pick < 22) put_byte(8'($urandom_range(0, 255)));
      else random_instr();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (TABLE_ENTRIES_DEF + 8) @(negedge clk);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    $display("Run covered %0d items (%0d table loads) and checked %0d decoded results,",
             items_sent, loads_sent, decoded_count);
    $display("%0d of them error results, with %0d long output hold-offs.", error_count,
             hold_ask);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
